@@ src/fctt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fctt_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int STACK_DEPTH = 1024;

    localparam int ADDR_W  = 32;
    localparam int INDEX_W = 10;
    localparam int DEPTH_W = 11;

    localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TBL_CW = $clog2(TABLE_DEPTH + 1);
    localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STK_CW = $clog2(STACK_DEPTH + 1);

    localparam logic [TBL_CW-1:0] TBL_FULL = TBL_CW'(TABLE_DEPTH);
    localparam logic [STK_CW-1:0] STK_FULL = STK_CW'(STACK_DEPTH);

    localparam logic [ADDR_W-1:0] RET_OFFSET = ADDR_W'(4);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_JUMP = 1'b1;

    localparam logic KIND_CALL = 1'b0;
    localparam logic KIND_RET  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] start;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

@@ src/fctt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fctt_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/fctt_match.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fctt_match (
    input  wire fctt_pkg::entry_t                  entry,
    input  wire logic [fctt_pkg::ADDR_W-1:0]       target,
    input  wire logic [fctt_pkg::ADDR_W-1:0]       pc,
    output logic                                   hit
);

    import fctt_pkg::*;

    // end of the function without wrap
    logic [ADDR_W:0] start_x;
    logic [ADDR_W:0] end_x;
    logic [ADDR_W:0] target_x;
    logic [ADDR_W:0] pc_x;
    logic            target_in;
    logic            pc_out;

    always_comb
    begin
        start_x   = {1'b0, entry.start};
        end_x     = start_x + {1'b0, entry.size};
        target_x  = {1'b0, target};
        pc_x      = {1'b0, pc};
        target_in = (start_x <= target_x) && (target_x < end_x);
        pc_out    = (pc_x < start_x) || (pc_x > end_x);
        hit       = (entry.start == target) || (target_in && pc_out);
    end

endmodule

`default_nettype wire

@@ src/function_call_trace_tracker_unit.sv @@
// load word: written into the table while idle; jump word: the stack top is checked in ST_TOP,
// then the table is searched in ST_SCAN; a return record is registered from ST_TOP, a call record
// from ST_SCAN; throughput: one word at a time; a load every cycle while idle; a jump word
// holds item_stall until its search ends, and longer while the record output is stalled
// reset: control state and counts clear asynchronously; table and stack contents are kept
`timescale 1ns / 1ps
`default_nettype none

module function_call_trace_tracker_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic                                mode,
    input  wire logic [fctt_pkg::INDEX_W-1:0]        entry_index,
    input  wire logic [fctt_pkg::ADDR_W-1:0]         entry_start,
    input  wire logic [fctt_pkg::ADDR_W-1:0]         entry_size,
    input  wire logic [fctt_pkg::ADDR_W-1:0]         jump_target,
    input  wire logic [fctt_pkg::ADDR_W-1:0]         jump_pc,
    output logic                                     record_valid,
    input  wire logic                                record_stall,
    output logic                                     record_kind,
    output logic      [fctt_pkg::INDEX_W-1:0]        function_slot,
    output logic      [fctt_pkg::DEPTH_W-1:0]        nest_depth,
    output logic      [fctt_pkg::ADDR_W-1:0]         record_pc,
    output logic                                     stack_overflow
);

    import fctt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TOP,
        ST_SCAN
    } state_t;

    state_t              state_reg, state_next;
    logic [TBL_CW-1:0]   scan_reg, scan_next;
    logic [TBL_CW-1:0]   tcount_reg, tcount_next;
    logic [STK_CW-1:0]   scount_reg, scount_next;
    logic [ADDR_W-1:0]   target_reg, target_next;
    logic [ADDR_W-1:0]   pc_reg, pc_next;

    logic                record_valid_reg, record_valid_next;
    logic                record_kind_reg, record_kind_next;
    logic [INDEX_W-1:0]  function_slot_reg, function_slot_next;
    logic [DEPTH_W-1:0]  nest_depth_reg, nest_depth_next;
    logic [ADDR_W-1:0]   record_pc_reg, record_pc_next;
    logic                stack_overflow_reg, stack_overflow_next;

    logic                tbl_we;
    logic [ENTRY_W-1:0]  tbl_rdata;
    entry_t              tbl_entry;
    entry_t              load_entry;
    logic                stk_we;
    logic [ADDR_W-1:0]   stk_rdata;
    logic                hit;
    logic                out_free;
    logic                emit_ret;
    logic                emit_call;

    assign load_entry = '{size: entry_size, start: entry_start};
    assign tbl_entry  = entry_t'(tbl_rdata);

    fctt_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (TBL_AW),
        .DW    (ENTRY_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (TBL_AW'(entry_index)),
        .wdata (load_entry),
        .raddr (TBL_AW'(scan_next)),
        .rdata (tbl_rdata)
    );

    // read port always points at the current top of stack
    fctt_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (STK_AW),
        .DW    (ADDR_W)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (STK_AW'(scount_reg)),
        .wdata (pc_reg),
        .raddr (STK_AW'(scount_reg - STK_CW'(1))),
        .rdata (stk_rdata)
    );

    fctt_match u_match (
        .entry  (tbl_entry),
        .target (target_reg),
        .pc     (pc_reg),
        .hit    (hit)
    );

    assign out_free = !record_valid_reg || !record_stall;

    always_comb
    begin
        state_next          = state_reg;
        scan_next           = scan_reg;
        tcount_next         = tcount_reg;
        scount_next         = scount_reg;
        target_next         = target_reg;
        pc_next             = pc_reg;
        record_valid_next   = record_valid_reg && record_stall;
        record_kind_next    = record_kind_reg;
        function_slot_next  = function_slot_reg;
        nest_depth_next     = nest_depth_reg;
        record_pc_next      = record_pc_reg;
        stack_overflow_next = stack_overflow_reg;
        tbl_we              = 1'b0;
        stk_we              = 1'b0;
        emit_ret            = 1'b0;
        emit_call           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (mode == MODE_LOAD)
                    begin
                        if (32'(entry_index) < 32'(TABLE_DEPTH))
                        begin
                            tbl_we      = 1'b1;
                            tcount_next = TBL_CW'(entry_index) + TBL_CW'(1);
                        end
                    end
                    else
                    begin
                        target_next = jump_target;
                        pc_next     = jump_pc;
                        scan_next   = '0;
                        state_next  = ST_TOP;
                    end
                end
            end

            ST_TOP:
            begin
                if ((scount_reg != '0) && (stk_rdata == target_reg - RET_OFFSET))
                begin
                    if (out_free)
                    begin
                        emit_ret            = 1'b1;
                        record_valid_next   = 1'b1;
                        record_kind_next    = KIND_RET;
                        function_slot_next  = '0;
                        nest_depth_next     = DEPTH_W'(scount_reg);
                        record_pc_next      = pc_reg;
                        stack_overflow_next = 1'b0;
                        scount_next         = scount_reg - STK_CW'(1);
                        state_next          = ST_IDLE;
                    end
                end
                else if (tcount_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    if (out_free)
                    begin
                        emit_call          = 1'b1;
                        record_valid_next  = 1'b1;
                        record_kind_next   = KIND_CALL;
                        function_slot_next = INDEX_W'(scan_reg);
                        record_pc_next     = pc_reg;
                        if (scount_reg < STK_FULL)
                        begin
                            stk_we              = 1'b1;
                            scount_next         = scount_reg + STK_CW'(1);
                            nest_depth_next     = DEPTH_W'(scount_reg + STK_CW'(1));
                            stack_overflow_next = 1'b0;
                        end
                        else
                        begin
                            nest_depth_next     = DEPTH_W'(STK_FULL);
                            stack_overflow_next = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else if (scan_reg + TBL_CW'(1) >= tcount_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    // next entry was fetched this cycle
                    scan_next = scan_reg + TBL_CW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            scan_reg           <= '0;
            tcount_reg         <= '0;
            scount_reg         <= '0;
            target_reg         <= '0;
            pc_reg             <= '0;
            record_valid_reg   <= 1'b0;
            record_kind_reg    <= KIND_CALL;
            function_slot_reg  <= '0;
            nest_depth_reg     <= '0;
            record_pc_reg      <= '0;
            stack_overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            scan_reg           <= scan_next;
            tcount_reg         <= tcount_next;
            scount_reg         <= scount_next;
            target_reg         <= target_next;
            pc_reg             <= pc_next;
            record_valid_reg   <= record_valid_next;
            record_kind_reg    <= record_kind_next;
            function_slot_reg  <= function_slot_next;
            nest_depth_reg     <= nest_depth_next;
            record_pc_reg      <= record_pc_next;
            stack_overflow_reg <= stack_overflow_next;
        end
    end

    assign item_stall     = (state_reg != ST_IDLE);
    assign record_valid   = record_valid_reg;
    assign record_kind    = record_kind_reg;
    assign function_slot  = function_slot_reg;
    assign nest_depth     = nest_depth_reg;
    assign record_pc      = record_pc_reg;
    assign stack_overflow = stack_overflow_reg;

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scount_reg <= STK_FULL)
        else $error("return stack count beyond depth");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        emit_ret |=> (scount_reg == $past(scount_reg) - STK_CW'(1)))
        else $error("return word did not pop the stack");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_call && (scount_reg < STK_FULL)) |=>
            (scount_reg == $past(scount_reg) + STK_CW'(1)) && !stack_overflow)
        else $error("call word did not push the stack");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_reg < tcount_reg))
        else $error("table walk past the entry count");

    a_ret_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (record_valid && (record_kind == KIND_RET)) |->
            (function_slot == '0) && !stack_overflow && (nest_depth != '0))
        else $error("malformed return word");

endmodule

`default_nettype wire
